[sv/gtg_pkg.sv]
// Shared types, constants and tables for the go-to-goal drive controller.
// No dependencies; imported by all modules.
package gtg_pkg;

  // Number of vectoring CORDIC iterations (8..24)
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  localparam logic [18:0] PI_Q16      = 19'd205887;
  localparam logic [18:0] HALF_PI_Q16 = 19'd102944;
  localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
  localparam logic [15:0] INV_GAIN    = 16'd39797;
  localparam logic [16:0] ONE_Q16     = 17'd65536;

  // Reciprocal of pi for the turn command: ceil(2^52 / PI_Q16). For any yaw
  // error below pi, (err * INV_PI_RECIP) >> 36 is exactly floor(err * 2^16 / pi).
  localparam logic [34:0] INV_PI_RECIP =
    35'(((64'd1 << 52) + 64'(PI_Q16) - 64'd1) / 64'(PI_Q16));

  // Action codes
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_GOAL = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;
  localparam logic [1:0] ACT_MGR  = 2'd3;

  // Pose status codes
  localparam logic [1:0] POSE_OK    = 2'd0;
  localparam logic [1:0] POSE_UNAVL = 2'd1;

  // Result status codes
  localparam logic [2:0] ST_TURNING = 3'd1;
  localparam logic [2:0] ST_DRIVING = 3'd2;
  localparam logic [2:0] ST_REACHED = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_ESTOP   = 3'd5;
  localparam logic [2:0] ST_POSE    = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_TURN_LIM  = 2'd2;
  localparam logic [1:0] REG_FULL_DIST = 2'd3;

  // Request to the divider: quotient of (num << 16) / den, num < den
  typedef struct packed {
    logic        start;
    logic [23:0] num;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
  } div_rsp_t;

  // Arctangent table, Q16 radians
  function automatic logic [15:0] atan_q16(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30386;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/gtg_if.sv]
// Valid/ready channel interfaces: item input, result output, register writes.
// Depends on nothing but the signal widths of the controller.
interface gtg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [30:0] target_x;
  logic signed [30:0] target_y;
  logic               target_ok;
  logic               shutdown;
  logic signed [30:0] pose_x;
  logic signed [30:0] pose_y;
  logic signed [18:0] pose_yaw;
  logic [1:0]         pose_status;
  modport source (output valid, action, target_x, target_y, target_ok, shutdown,
                  pose_x, pose_y, pose_yaw, pose_status, input ready);
  modport sink (input valid, action, target_x, target_y, target_ok, shutdown,
                pose_x, pose_y, pose_yaw, pose_status, output ready);
endinterface

interface gtg_out_if;
  logic               valid;
  logic               ready;
  logic               move_emit;
  logic [16:0]        forward_cmd;
  logic signed [17:0] turn_cmd;
  logic               mode_emit;
  logic               motion_mode;
  logic [2:0]         status;
  modport source (output valid, move_emit, forward_cmd, turn_cmd, mode_emit,
                  motion_mode, status, input ready);
  modport sink (input valid, move_emit, forward_cmd, turn_cmd, mode_emit,
                motion_mode, status, output ready);
endinterface

interface gtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/gtg_div.sv]
// Radix-2 restoring divider: 16-bit fraction quotient of num/den, num < den.
// Depends on gtg_pkg for the request/response structs.
module gtg_div (
  input  logic              clk,
  input  logic              rst,
  input  gtg_pkg::div_req_t req,
  output gtg_pkg::div_rsp_t rsp
);
  import gtg_pkg::*;

  logic [23:0] rem;
  logic [15:0] quo;
  logic [3:0]  cnt;
  logic        busy;
  logic        done;
  logic [24:0] rem2;
  logic        fits;

  // One quotient bit per cycle
  assign rem2 = {rem, 1'b0};
  assign fits = rem2 >= {1'b0, req.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= req.num;
        quo  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        rem <= fits ? 24'(rem2 - {1'b0, req.den}) : rem2[23:0];
        quo <= {quo[14:0], fits};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

[sv/go_to_goal_drive_controller_unit.sv]
// Top level of the go-to-goal drive controller: control sequencer, CORDIC
// datapath and result register. Depends on gtg_pkg, gtg_if.sv and gtg_div.
//
// Usage:
//   req : one item per transfer (tick, new goal, drive stop, manager command).
//   rsp : at most one result per item (move/turn command, mode, status).
//   cfg : register writes, ready only while the sequencer is idle.
// req.ready is high only while the sequencer is idle; one item is in work at
// a time. Goal, stop and manager items and ticks that end early go straight
// to S_EMIT, which loads their result, if any, once rsp is free; the next
// item can be taken when it returns to idle. A full tick runs the CORDIC
// (CORDIC_STEPS iterations, one shared shift-add unit), the multiply state
// S_MUL and the check state S_CHECK, in which the turn command comes from a
// reciprocal multiply, and then S_EMIT loads the result. When the forward
// command needs scaling, one divider pass in S_FWD comes before S_EMIT. The
// result register decouples the sides: a new item may be taken while a result
// still waits; the sequencer holds its next result while rsp is stalled.
// Reset clears the goal, halted flag, tick count and mode (turn in place) and
// loads the register defaults.
module go_to_goal_drive_controller_unit (
  input  logic clk,
  input  logic rst,
  gtg_in_if.sink    req,
  gtg_out_if.source rsp,
  gtg_cfg_if.sink   cfg
);
  import gtg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROT, S_MUL, S_CHECK, S_FWD, S_EMIT
  } state_t;

  state_t state;

  // Configuration
  logic [15:0] timeout_ticks;
  logic [23:0] tolerance;
  logic [17:0] turn_limit;
  logic [23:0] full_speed_distance;

  // Controller state
  logic signed [30:0] goal_px, goal_py;
  logic               goal_active, halted, mode_now;
  logic [15:0]        tick_count;

  // Datapath
  logic signed [34:0] cx, cy;
  logic signed [19:0] cz;
  logic [STEP_W-1:0]  step;
  logic signed [18:0] yaw;
  logic [33:0]        goal_dist;
  logic signed [20:0] err;
  logic               have_res;

  // Result being built
  logic               r_move, r_me;
  logic [16:0]        r_fwd;
  logic signed [17:0] r_turn;
  logic [2:0]         r_st;

  div_req_t dreq;
  div_rsp_t drsp;

  gtg_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Input-side helpers
  logic [15:0]        tc_next;
  logic signed [34:0] dx, dy;
  assign tc_next = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
  assign dx = 35'(goal_px) - 35'(req.pose_x);
  assign dy = 35'(goal_py) - 35'(req.pose_y);

  // Item decode: result, stop and compute decisions at the transfer
  logic       i_res, i_move, i_drop, i_rot;
  logic [2:0] i_st;
  always_comb begin
    i_res  = 1'b0;
    i_move = 1'b1;
    i_drop = 1'b0;
    i_rot  = 1'b0;
    i_st   = ST_ESTOP;
    case (req.action)
      ACT_GOAL: begin
        if (!req.target_ok) begin
          i_res  = 1'b1;
          i_drop = 1'b1;
        end
      end
      ACT_STOP: begin
        i_res  = 1'b1;
        i_drop = 1'b1;
      end
      ACT_MGR: begin
        if (req.shutdown && !halted) begin
          i_res  = 1'b1;
          i_drop = 1'b1;
        end
      end
      ACT_TICK: begin
        if (goal_active && !halted) begin
          if (tc_next > timeout_ticks) begin
            i_res  = 1'b1;
            i_drop = 1'b1;
            i_st   = ST_TIMEOUT;
          end else if (req.pose_status == POSE_UNAVL) begin
            i_res  = 1'b1;
            i_move = 1'b0;
            i_st   = ST_POSE;
          end else if (req.pose_status != POSE_OK) begin
            i_res  = 1'b1;
            i_drop = 1'b1;
            i_st   = ST_POSE;
          end else begin
            i_rot = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // CORDIC shift-add step
  logic signed [34:0] xs, ys;
  logic signed [19:0] at;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = 20'(signed'({1'b0, atan_q16(5'(step))}));

  // Gain correction and yaw error
  logic [49:0]        prod;
  logic signed [20:0] e0, ew;
  assign prod = 50'(cx[33:0]) * 50'(INV_GAIN) + 50'd32768;
  assign e0 = 21'(cz) - 21'(yaw);
  always_comb begin
    if (e0 > 21'(signed'({1'b0, PI_Q16})))        ew = e0 - 21'(TWO_PI_Q16);
    else if (e0 < -21'(signed'({1'b0, PI_Q16})))  ew = e0 + 21'(TWO_PI_Q16);
    else                                          ew = e0;
  end

  logic [19:0] abserr;
  logic        want;
  assign abserr = err[20] ? 20'(-err) : 20'(err);
  assign want   = !(abserr > 20'(turn_limit));

  // Turn magnitude: yaw error over pi, valid while the error is below pi
  logic [52:0] yprod;
  logic [15:0] yaw_quo;
  assign yprod   = 53'(abserr[17:0]) * 53'(INV_PI_RECIP);
  assign yaw_quo = yprod[51:36];

  // Check-cycle decisions
  logic near_goal, far_goal, div_go;
  assign near_goal = goal_dist < 34'(tolerance);
  assign far_goal  = goal_dist >= 34'(full_speed_distance);
  assign div_go    = (state == S_CHECK) && !near_goal && want && !far_goal;

  // Divider request: forward command scaling only
  logic div_start;
  always_comb begin
    dreq.start = div_start;
    dreq.num   = goal_dist[23:0];
    dreq.den   = full_speed_distance;
  end

  logic out_free;
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      timeout_ticks       <= 16'd450;
      tolerance           <= 24'd9830;
      turn_limit          <= 18'd26214;
      full_speed_distance <= 24'd163840;
      goal_active         <= 1'b0;
      halted              <= 1'b0;
      mode_now            <= 1'b0;
      tick_count          <= '0;
      goal_px             <= '0;
      goal_py             <= '0;
      rsp.valid           <= 1'b0;
      div_start           <= 1'b0;
      have_res            <= 1'b0;
    end else begin
      div_start <= div_go;
      if (state == S_EMIT && have_res && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready)                         rsp.valid <= 1'b0;

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TIMEOUT:   timeout_ticks       <= cfg.data[15:0];
          REG_TOLERANCE: tolerance           <= cfg.data;
          REG_TURN_LIM:  turn_limit          <= cfg.data[17:0];
          REG_FULL_DIST: full_speed_distance <= cfg.data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            // Default result: zero-move stop
            r_move   <= i_move;
            r_fwd    <= '0;
            r_turn   <= '0;
            r_me     <= 1'b0;
            r_st     <= i_st;
            have_res <= i_res;
            state    <= i_rot ? S_ROT : S_EMIT;
            if (i_drop) goal_active <= 1'b0;
            case (req.action)
              ACT_GOAL: begin
                if (req.target_ok) begin
                  goal_px     <= req.target_x;
                  goal_py     <= req.target_y;
                  goal_active <= 1'b1;
                  tick_count  <= '0;
                end
              end
              ACT_MGR: begin
                halted <= req.shutdown;
              end
              ACT_TICK: begin
                if (goal_active) tick_count <= tc_next;
              end
              default: ;
            endcase
            if (i_rot) begin
              // Pre-rotate into the right half plane
              yaw  <= req.pose_yaw;
              step <= '0;
              if (dx < 0) begin
                if (dy >= 0) begin
                  cx <= dy;
                  cy <= -dx;
                  cz <= 20'(HALF_PI_Q16);
                end else begin
                  cx <= -dy;
                  cy <= dx;
                  cz <= -20'(HALF_PI_Q16);
                end
              end else begin
                cx <= dx;
                cy <= dy;
                cz <= '0;
              end
            end
          end
        end
        S_ROT: begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end
          step <= step + 1'b1;
          if (step == STEP_W'(CORDIC_STEPS - 1)) state <= S_MUL;
        end
        S_MUL: begin
          goal_dist <= prod[49:16];
          err       <= ew;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          have_res <= 1'b1;
          if (near_goal) begin
            goal_active <= 1'b0;
            r_st        <= ST_REACHED;
            state       <= S_EMIT;
          end else begin
            r_me     <= (want != mode_now);
            mode_now <= want;
            r_st     <= want ? ST_DRIVING : ST_TURNING;
            r_fwd    <= want ? ONE_Q16 : '0;
            // Turn command saturates at a yaw error of pi
            if (abserr >= 20'(PI_Q16)) begin
              r_turn <= err[20] ? -18'(ONE_Q16) : 18'(ONE_Q16);
            end else begin
              r_turn <= err[20] ? -18'(yaw_quo) : 18'(yaw_quo);
            end
            state <= div_go ? S_FWD : S_EMIT;
          end
        end
        S_FWD: begin
          if (drsp.done) begin
            r_fwd <= 17'(drsp.quo);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!have_res) begin
            state <= S_IDLE;
          end else if (out_free) begin
            rsp.move_emit   <= r_move;
            rsp.forward_cmd <= r_fwd;
            rsp.turn_cmd    <= r_turn;
            rsp.mode_emit   <= r_me;
            rsp.motion_mode <= mode_now;
            rsp.status      <= r_st;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Only a pose-unavailable report carries no move
  a_nomove_pose: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.move_emit |-> rsp.status == ST_POSE)
    else $error("result without move must report pose problem");
  // Stop results carry zero commands and no mode change
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_TURNING && rsp.status != ST_DRIVING
      |-> rsp.forward_cmd == '0 && rsp.turn_cmd == '0 && !rsp.mode_emit)
    else $error("stop result with nonzero command");
  // Turning in place never drives forward
  a_turn_mode: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_TURNING |-> rsp.forward_cmd == '0 && !rsp.motion_mode)
    else $error("turn result inconsistent with mode");
  // Divider is only started for forward scaling
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_FWD)
    else $error("divider started outside compute");
`endif

endmodule
